>>> rtl/core/wzh_pkg.sv
// Shared types, constants and helpers for the window Zobrist hash block.
// No dependencies.
package wzh_pkg;

  localparam int unsigned MAX_WINDOW  = 7;
  localparam int unsigned MAX_BOARD   = 19;
  localparam int unsigned COLOR_COUNT = 4;

  // input beat kinds, carried in tuser
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_CELL  = 2'd2
  } op_e;

  // configuration register indexes
  localparam logic [1:0] CFG_WINDOW_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_WINDOW_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BOARD_WIDTH   = 2'd2;
  localparam logic [1:0] CFG_BOARD_HEIGHT  = 2'd3;

  localparam logic [1:0] COLOR_BLACK = 2'd1;
  localparam logic [1:0] COLOR_WHITE = 2'd2;

  // window dimension: 0 acts as 1, clamp to MAX_WINDOW
  function automatic logic [2:0] win_dim(input logic [2:0] v);
    logic [2:0] r;
    r = (v == 3'd0) ? 3'd1 : v;
    if (32'(r) > MAX_WINDOW) r = 3'(MAX_WINDOW);
    return r;
  endfunction

  function automatic logic [4:0] board_dim(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (32'(r) > MAX_BOARD) r = 5'(MAX_BOARD);
    return r;
  endfunction

  // black/white swap, empty and wall pass through
  function automatic logic [1:0] swap_color(input logic [1:0] c, input logic flip);
    logic [1:0] r;
    r = c;
    if (flip && (c == COLOR_BLACK || c == COLOR_WHITE)) r = ~c;
    return r;
  endfunction

endpackage

>>> rtl/core/window_zobrist_hash.sv
// Window Zobrist hash: table storage, query sequencing and hash accumulation.
// Depends on wzh_pkg.
//
// Throughput: one beat per cycle for every beat kind (load, start, cell),
// while the result stream does not stall. A result reaches the master side
// through the input register, table read and accumulate into the output reg.
// Reset: control state, configuration (5/5/19/19) and accumulator clear at
// once; the three word tables are not cleared and hold garbage until loaded.
// No clearing pass, the block is ready right after reset.
module window_zobrist_hash
  import wzh_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [4:0]   cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, from bit 0: table_address[9], word_high[64], word_low[64], player[2],
  // symmetry[3], flip_colors[1], no_location[1], center_x[5], center_y[5],
  // cell_color[2], single_liberty[1], 3 zero pad bits
  input  logic [159:0] s_axis_tdata,
  // tuser, from bit 0: op[2]
  input  logic [1:0]   s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata, from bit 0: hash_high[64], hash_low[64]
  output logic [127:0] m_axis_tdata
);

  typedef enum logic [1:0] {
    S2_IDLE,
    S2_START,
    S2_CELL
  } s2_kind_e;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [2:0] cfg_ww_q, cfg_wh_q;
  logic [4:0] cfg_bw_q, cfg_bh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ww_q <= 3'd5;
      cfg_wh_q <= 3'd5;
      cfg_bw_q <= 5'd19;
      cfg_bh_q <= 5'd19;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW_WIDTH:  cfg_ww_q <= cfg_data_i[2:0];
        CFG_WINDOW_HEIGHT: cfg_wh_q <= cfg_data_i[2:0];
        CFG_BOARD_WIDTH:   cfg_bw_q <= cfg_data_i;
        CFG_BOARD_HEIGHT:  cfg_bh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic         s1_valid_q;
  logic [1:0]   s1_op_q;
  logic [8:0]   s1_addr_q;
  logic [127:0] s1_word_q;     // {word_high, word_low}
  logic [1:0]   s1_player_q;
  logic [2:0]   s1_sym_q;
  logic         s1_flip_q;
  logic         s1_noloc_q;
  logic [4:0]   s1_cx_q, s1_cy_q;
  logic [1:0]   s1_color_q;
  logic         s1_lib_q;

  logic s2_adv;    // stage 2 moves on this cycle
  logic s1_go;     // stage 1 beat is processed this cycle

  assign s_axis_tready = !s1_valid_q || s2_adv;
  assign s1_go         = s1_valid_q && s2_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_op_q     <= s_axis_tuser;
      s1_addr_q   <= s_axis_tdata[8:0];
      s1_word_q   <= {s_axis_tdata[72:9], s_axis_tdata[136:73]};
      s1_player_q <= s_axis_tdata[138:137];
      s1_sym_q    <= s_axis_tdata[141:139];
      s1_flip_q   <= s_axis_tdata[142];
      s1_noloc_q  <= s_axis_tdata[143];
      s1_cx_q     <= s_axis_tdata[148:144];
      s1_cy_q     <= s_axis_tdata[153:149];
      s1_color_q  <= s_axis_tdata[155:154];
      s1_lib_q    <= s_axis_tdata[156];
    end
  end

  // ---------------------------------------------------------------------------
  // Query state (updated as beats leave stage 1)
  // ---------------------------------------------------------------------------
  logic       active_q;
  logic [2:0] col_q, row_q;
  logic [2:0] q_sym_q;
  logic       q_flip_q;
  logic [4:0] q_cx_q, q_cy_q;

  // ---------------------------------------------------------------------------
  // Stage 1 decode: window position, board clipping, table addresses
  // ---------------------------------------------------------------------------
  op_e        s1_op;
  logic [2:0] win_w, win_h, half_w, half_h;
  logic [4:0] brd_w, brd_h;
  logic [5:0] sum_x, sum_y, area;
  logic       x_ok, y_ok, in_win, on_board;
  logic [2:0] sx, sy;
  logic [5:0] pos;
  logic [1:0] cell_c;
  logic       pat_use, lib_use, last;
  logic [7:0] pat_addr;
  logic [1:0] pla_idx;
  logic       pla_ok;
  logic [3:0] col_inc;
  logic [2:0] col_d, row_d;
  logic       pat_we, pla_we, lib_we;

  always_comb begin
    s1_op  = op_e'(s1_op_q);
    win_w  = win_dim(cfg_ww_q);
    win_h  = win_dim(cfg_wh_q);
    half_w = win_w >> 1;
    half_h = win_h >> 1;
    brd_w  = board_dim(cfg_bw_q);
    brd_h  = board_dim(cfg_bh_q);

    // board column = center + col - half, must lie in [0, board)
    sum_x = {1'b0, q_cx_q} + {3'b000, col_q};
    sum_y = {1'b0, q_cy_q} + {3'b000, row_q};
    x_ok  = (sum_x >= {3'b000, half_w}) && ((sum_x - {3'b000, half_w}) < {1'b0, brd_w});
    y_ok  = (sum_y >= {3'b000, half_h}) && ((sum_y - {3'b000, half_h}) < {1'b0, brd_h});
    in_win   = (col_q < win_w) && (row_q < win_h);
    on_board = in_win && x_ok && y_ok;

    // symmetric window position
    sx  = q_sym_q[1] ? (win_w - 3'd1 - col_q) : col_q;
    sy  = q_sym_q[0] ? (win_h - 3'd1 - row_q) : row_q;
    pos = q_sym_q[2] ? ({3'b000, sx} * {3'b000, win_h}) + {3'b000, sy}
                     : ({3'b000, sy} * {3'b000, win_w}) + {3'b000, sx};
    area = {3'b000, win_w} * {3'b000, win_h};

    cell_c   = swap_color(s1_color_q, q_flip_q);
    pat_use  = on_board && ({1'b0, cell_c} < 3'(COLOR_COUNT));
    pat_addr = ({6'd0, cell_c} * {2'b00, area}) + {2'b00, pos};
    lib_use  = on_board && s1_lib_q &&
               (s1_color_q == COLOR_BLACK || s1_color_q == COLOR_WHITE);
    last     = (row_q >= win_h - 3'd1) && (col_q >= win_w - 3'd1);

    col_inc = {1'b0, col_q} + 4'd1;
    if (col_inc >= {1'b0, win_w}) begin
      col_d = 3'd0;
      row_d = row_q + 3'd1;
    end else begin
      col_d = col_inc[2:0];
      row_d = row_q;
    end

    pla_idx = swap_color(s1_player_q, s1_flip_q);
    pla_ok  = {1'b0, pla_idx} < 3'(COLOR_COUNT);

    // table write decode: 0-255 pattern, 256-259 player, 384-447 liberty
    pat_we = s1_go && (s1_op == OP_LOAD) && !s1_addr_q[8];
    pla_we = s1_go && (s1_op == OP_LOAD) && (s1_addr_q[8:2] == 7'b1000000) &&
             ({1'b0, s1_addr_q[1:0]} < 3'(COLOR_COUNT));
    lib_we = s1_go && (s1_op == OP_LOAD) && (s1_addr_q[8:6] == 3'b110);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      col_q    <= 3'd0;
      row_q    <= 3'd0;
      q_sym_q  <= 3'd0;
      q_flip_q <= 1'b0;
      q_cx_q   <= 5'd0;
      q_cy_q   <= 5'd0;
    end else if (s1_go) begin
      case (s1_op)
        OP_START: begin
          active_q <= !s1_noloc_q;
          col_q    <= 3'd0;
          row_q    <= 3'd0;
          q_sym_q  <= s1_sym_q;
          q_flip_q <= s1_flip_q;
          q_cx_q   <= s1_cx_q;
          q_cy_q   <= s1_cy_q;
        end
        OP_CELL: begin
          if (active_q) begin
            if (last) begin
              active_q <= 1'b0;
              col_q    <= 3'd0;
              row_q    <= 3'd0;
            end else begin
              col_q <= col_d;
              row_q <= row_d;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Word tables, read data registered into stage 2
  // ---------------------------------------------------------------------------
  logic [127:0] pat_mem [256];
  logic [127:0] lib_mem [64];
  logic [127:0] pla_mem [4];
  logic [127:0] pat_rd_q, lib_rd_q, pla_rd_q;

  always_ff @(posedge clk_i) begin
    if (pat_we) pat_mem[s1_addr_q[7:0]] <= s1_word_q;
    if (s1_go)  pat_rd_q <= pat_mem[pat_addr];
  end

  always_ff @(posedge clk_i) begin
    if (lib_we) lib_mem[s1_addr_q[5:0]] <= s1_word_q;
    if (s1_go)  lib_rd_q <= lib_mem[pos];
  end

  always_ff @(posedge clk_i) begin
    if (pla_we) pla_mem[s1_addr_q[1:0]] <= s1_word_q;
    if (s1_go)  pla_rd_q <= pla_mem[pla_idx];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: accumulate and emit
  // ---------------------------------------------------------------------------
  s2_kind_e s2_kind_q;
  logic     s2_pat_q, s2_lib_q, s2_last_q, s2_noloc_q, s2_pla_ok_q;
  logic     s2_emit, out_free;

  logic [127:0] acc_q, acc_d;
  logic [127:0] out_q;
  logic         out_valid_q;

  assign out_free = !out_valid_q || m_axis_tready;
  assign s2_emit  = ((s2_kind_q == S2_START) && s2_noloc_q) ||
                    ((s2_kind_q == S2_CELL) && s2_last_q);
  assign s2_adv   = !s2_emit || out_free;

  always_comb begin
    case (s2_kind_q)
      S2_START: acc_d = s2_pla_ok_q ? pla_rd_q : '0;
      S2_CELL:  acc_d = acc_q ^ (s2_pat_q ? pat_rd_q : '0) ^ (s2_lib_q ? lib_rd_q : '0);
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_kind_q <= S2_IDLE;
    end else if (s2_adv) begin
      if (s1_valid_q && s1_op == OP_START) begin
        s2_kind_q <= S2_START;
      end else if (s1_valid_q && s1_op == OP_CELL && active_q) begin
        s2_kind_q <= S2_CELL;
      end else begin
        s2_kind_q <= S2_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_pat_q    <= pat_use;
      s2_lib_q    <= lib_use;
      s2_last_q   <= last;
      s2_noloc_q  <= s1_noloc_q;
      s2_pla_ok_q <= pla_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_adv) acc_q <= acc_d;
      if (out_free) out_valid_q <= s2_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_emit && out_free) out_q <= acc_d;
  end

  // out_q holds {hash_high, hash_low}; hash_high goes to the low bits
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q[63:0], out_q[127:64]};

endmodule
